FILE: hdl/i2cm_pkg.sv
// Shared types and constants for the bit-level I2C master.
`timescale 1ns / 1ps
package i2cm_pkg;

  localparam int CMD_W       = 3;
  localparam int BYTE_W      = 8;
  localparam int DELAY_CFG_W = 16;
  localparam int STEP_W      = 4;
  localparam int BIT_IDX_W   = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [DELAY_CFG_W-1:0] DELAY_RESET   = 16'd10;
  localparam logic [BIT_IDX_W-1:0]   BITS_PER_BYTE = 4'd8;

  // Command codes on the request channel
  localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

  // Sequencer operation; OP_IDLE in a queued item means "no command"
  typedef enum logic [4:0] {
    OP_IDLE  = 5'b00001,
    OP_START = 5'b00010,
    OP_STOP  = 5'b00100,
    OP_WRITE = 5'b01000,
    OP_READ  = 5'b10000
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] write_byte;
    logic              nak_reply;
    logic              sda_in;
  } item_t;

  typedef struct packed {
    logic              scl_drive_low;
    logic              sda_drive_low;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_byte;
    logic              no_ack;
  } result_t;

endpackage

FILE: hdl/i2cm_req_if.sv
// Request channel: one tick of command and line sample per transaction.
`timescale 1ns / 1ps
interface i2cm_req_if;
  logic                       valid;
  logic                       ready;
  logic [i2cm_pkg::CMD_W-1:0]  cmd;
  logic [i2cm_pkg::BYTE_W-1:0] write_byte;
  logic                       nak_reply;
  logic                       sda_in;

  modport source (output valid, cmd, write_byte, nak_reply, sda_in, input ready);
  modport sink (input valid, cmd, write_byte, nak_reply, sda_in, output ready);
endinterface

FILE: hdl/i2cm_rsp_if.sv
// Result channel: pin drives and status after each tick.
`timescale 1ns / 1ps
interface i2cm_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       scl_drive_low;
  logic                       sda_drive_low;
  logic                       busy_res;
  logic                       done_res;
  logic [i2cm_pkg::BYTE_W-1:0] read_byte;
  logic                       no_ack;

  modport source (output valid, scl_drive_low, sda_drive_low, busy_res, done_res,
                  read_byte, no_ack, input ready);
  modport sink (input valid, scl_drive_low, sda_drive_low, busy_res, done_res,
                read_byte, no_ack, output ready);
endinterface

FILE: hdl/i2cm_front.sv
// Front end: accepts request transactions and decodes the command code.
`timescale 1ns / 1ps
module i2cm_front (
  i2cm_req_if.sink      req,
  input  logic          q_full,
  output logic          push,
  output i2cm_pkg::item_t push_item
);
  import i2cm_pkg::*;

  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;

  always_comb begin
    push_item.write_byte = req.write_byte;
    push_item.nak_reply  = req.nak_reply;
    push_item.sda_in     = req.sda_in;
    unique case (req.cmd)
      CMD_START: push_item.op = OP_START;
      CMD_STOP:  push_item.op = OP_STOP;
      CMD_WRITE: push_item.op = OP_WRITE;
      CMD_READ:  push_item.op = OP_READ;
      default:   push_item.op = OP_IDLE;  // none and unused codes
    endcase
  end

endmodule

FILE: hdl/i2cm_queue.sv
// Small FIFO between the front end and the sequencer.
`timescale 1ns / 1ps
module i2cm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  i2cm_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output i2cm_pkg::item_t head_item
);
  import i2cm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  item_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + CNT_W'(1);
    else if (pop && !push) count_next = count - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      count <= count_next;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue pushed while full");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count past depth");

endmodule

FILE: hdl/i2cm_back.sv
// Sequencer: runs the pin step lists one tick per queued transaction.
`timescale 1ns / 1ps
module i2cm_back #(
  parameter int DELAY_COUNTER_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [i2cm_pkg::DELAY_CFG_W-1:0]     delay_ticks,
  input  logic                                head_valid,
  input  i2cm_pkg::item_t                     head_item,
  output logic                                pop,
  i2cm_rsp_if.source                          rsp
);
  import i2cm_pkg::*;

  localparam int CW = DELAY_COUNTER_BITS;
  localparam int MW = (CW > DELAY_CFG_W) ? CW : DELAY_CFG_W;

  // sequencer state
  op_t                   op, op_next;
  logic [STEP_W-1:0]     step, step_next;
  logic [BIT_IDX_W-1:0]  bit_idx, bit_idx_next;
  logic [BYTE_W-1:0]     shift, shift_next;
  logic [CW-1:0]         dcnt, dcnt_next;
  logic                  scl_low, scl_low_next;
  logic                  sda_low, sda_low_next;
  logic                  nak, nak_next;
  logic                  ack, ack_next;
  logic [BYTE_W-1:0]     last_read, last_read_next;
  logic                  done;

  logic [STEP_W-1:0]     nstep;
  logic                  has_next;
  logic [BIT_IDX_W-1:0]  bit_inc;

  logic [DELAY_CFG_W-1:0] rl_cfg;
  logic [MW-1:0]          rl_wide;
  logic [CW-1:0]          reload;

  result_t               res_next;
  result_t               out_res;
  logic                  out_valid;

  // delay unit reload: zero counts as one, clipped to the counter range
  assign rl_cfg  = (delay_ticks == '0) ? '0 : delay_ticks - DELAY_CFG_W'(1);
  assign rl_wide = MW'(rl_cfg);
  assign reload  = (rl_wide > MW'({CW{1'b1}})) ? {CW{1'b1}} : rl_wide[CW-1:0];

  assign bit_inc = bit_idx + BIT_IDX_W'(1);

  assign pop = head_valid && (!out_valid || rsp.ready);

  // step successor
  always_comb begin
    nstep    = step + STEP_W'(1);
    has_next = 1'b0;
    unique case (op)
      OP_START: has_next = (step < 4'd3);
      OP_STOP:  has_next = (step < 4'd4);
      OP_WRITE: begin
        has_next = (step < 4'd8);
        if (step == 4'd5) nstep = (bit_idx < BITS_PER_BYTE) ? 4'd2 : 4'd6;
      end
      OP_READ: begin
        has_next = (step < 4'd9);
        if (step == 4'd3) nstep = (bit_idx < BITS_PER_BYTE) ? 4'd4 : 4'd5;
        else if (step == 4'd4) nstep = 4'd1;
      end
      default: has_next = 1'b0;
    endcase
  end

  always_comb begin
    op_next        = op;
    step_next      = step;
    bit_idx_next   = bit_idx;
    shift_next     = shift;
    dcnt_next      = dcnt;
    scl_low_next   = scl_low;
    sda_low_next   = sda_low;
    nak_next       = nak;
    ack_next       = ack;
    last_read_next = last_read;
    done           = 1'b0;
    if (pop) begin
      if (op == OP_IDLE) begin
        if (head_item.op != OP_IDLE) begin
          op_next      = head_item.op;
          step_next    = '0;
          bit_idx_next = '0;
          nak_next     = head_item.nak_reply;
          dcnt_next    = reload;
          if (head_item.op == OP_WRITE) shift_next = head_item.write_byte;
          if (head_item.op == OP_READ) begin
            shift_next   = '0;
            sda_low_next = 1'b0;
          end
        end
      end else if (dcnt != '0) begin
        dcnt_next = dcnt - CW'(1);
      end else if (has_next) begin
        step_next = nstep;
        dcnt_next = reload;
        unique case (op)
          OP_START: begin
            case (nstep)
              4'd1:    scl_low_next = 1'b0;
              4'd2:    sda_low_next = 1'b1;
              4'd3:    scl_low_next = 1'b1;
              default: ;
            endcase
          end
          OP_STOP: begin
            case (nstep)
              4'd1:    sda_low_next = 1'b1;
              4'd2:    scl_low_next = 1'b1;
              4'd3:    scl_low_next = 1'b0;
              4'd4:    sda_low_next = 1'b0;
              default: ;
            endcase
          end
          OP_WRITE: begin
            case (nstep)
              4'd1: scl_low_next = 1'b1;
              4'd2: begin
                sda_low_next = !shift[BYTE_W-1];
                shift_next   = {shift[BYTE_W-2:0], 1'b0};
              end
              4'd3: scl_low_next = 1'b0;
              4'd5: begin
                scl_low_next = 1'b1;
                bit_idx_next = bit_inc;
                if (bit_inc >= BITS_PER_BYTE) sda_low_next = 1'b0;  // free SDA for ACK
              end
              4'd6: scl_low_next = 1'b0;
              4'd8: begin
                ack_next     = head_item.sda_in;
                scl_low_next = 1'b1;
              end
              default: ;
            endcase
          end
          OP_READ: begin
            case (nstep)
              4'd1: scl_low_next = 1'b0;
              4'd3: begin
                shift_next   = {shift[BYTE_W-2:0], head_item.sda_in};
                scl_low_next = 1'b1;
                bit_idx_next = bit_inc;
              end
              4'd5:    sda_low_next = !nak;
              4'd7:    scl_low_next = 1'b0;
              4'd9:    scl_low_next = 1'b1;
              default: ;
            endcase
          end
          default: ;
        endcase
      end else begin
        if (op == OP_READ) last_read_next = shift;
        op_next   = OP_IDLE;
        step_next = '0;
        done      = 1'b1;
      end
    end
  end

  always_comb begin
    res_next.scl_drive_low = scl_low_next;
    res_next.sda_drive_low = sda_low_next;
    res_next.busy_res      = (op_next != OP_IDLE);
    res_next.done_res      = done;
    res_next.read_byte     = last_read_next;
    res_next.no_ack        = ack_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op        <= OP_IDLE;
      step      <= '0;
      bit_idx   <= '0;
      shift     <= '0;
      dcnt      <= '0;
      scl_low   <= 1'b0;
      sda_low   <= 1'b0;
      nak       <= 1'b0;
      ack       <= 1'b0;
      last_read <= '0;
      out_valid <= 1'b0;
    end else begin
      op        <= op_next;
      step      <= step_next;
      bit_idx   <= bit_idx_next;
      shift     <= shift_next;
      dcnt      <= dcnt_next;
      scl_low   <= scl_low_next;
      sda_low   <= sda_low_next;
      nak       <= nak_next;
      ack       <= ack_next;
      last_read <= last_read_next;
      if (pop) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_res <= res_next;
  end

  assign rsp.valid         = out_valid;
  assign rsp.scl_drive_low = out_res.scl_drive_low;
  assign rsp.sda_drive_low = out_res.sda_drive_low;
  assign rsp.busy_res      = out_res.busy_res;
  assign rsp.done_res      = out_res.done_res;
  assign rsp.read_byte     = out_res.read_byte;
  assign rsp.no_ack        = out_res.no_ack;

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    (pop && op != OP_IDLE && dcnt == '0 && !has_next)
      |=> (op == OP_IDLE && out_valid && out_res.done_res && !out_res.busy_res))
    else $error("finished command did not return to idle with done");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_idx <= BITS_PER_BYTE)
    else $error("bit index past one byte");

  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    op == OP_IDLE |-> step == '0)
    else $error("idle with nonzero step");

endmodule

FILE: hdl/i2c_bit_level_master_top.sv
// Top level of the bit-level I2C master.
// Usage:
//   req  - one transaction per clock tick of the pin sequencer: cmd (none, start,
//          stop, write byte, read byte), write_byte, nak_reply and the SDA sample.
//          Commands seen while a sequence is running are dropped.
//   rsp  - exactly one transaction back per req transaction, in order: SCL/SDA
//          pull-down drives, busy, a one-tick done pulse, last read byte, no_ack.
//   cfg_we/cfg_wdata - writes delay_ticks (ticks per delay unit, reset 10);
//          write only while idle.
// Throughput: one transaction per cycle sustained; the sequencer retires one
//   queued tick per cycle whenever its output register is free or being taken.
// Path: an accepted req transaction goes via the queue and output register to rsp.
// Stall: if rsp.ready is low the output register holds, the two-entry queue
//   fills, and req.ready drops; no tick is lost or repeated.
// Reset (rst, synchronous): lines released, sequencer idle, queue empty,
//   delay_ticks back to 10.
`timescale 1ns / 1ps
module i2c_bit_level_master_top #(
  parameter int DELAY_COUNTER_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  i2cm_req_if.sink                        req,
  i2cm_rsp_if.source                      rsp,
  input  logic                            cfg_we,
  input  logic [i2cm_pkg::DELAY_CFG_W-1:0] cfg_wdata
);
  import i2cm_pkg::*;

  logic [DELAY_CFG_W-1:0] delay_ticks;

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  pop;
  logic  head_valid;
  item_t head_item;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= DELAY_RESET;
    end else if (cfg_we) begin
      delay_ticks <= cfg_wdata;
    end
  end

  // front end: take the tick, decode the command
  i2cm_front u_front (
    .req       (req),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // decoupling queue
  i2cm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // sequencer and output register
  i2cm_back #(
    .DELAY_COUNTER_BITS (DELAY_COUNTER_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .delay_ticks (delay_ticks),
    .head_valid  (head_valid),
    .head_item   (head_item),
    .pop         (pop),
    .rsp         (rsp)
  );

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the bit-level I2C master: predicted pin/status per tick.
`timescale 1ns / 1ps
module testbench;
  import i2cm_pkg::*;

  // Counter width used for both the instance and the tick predictor.
  localparam int COUNTER_BITS = 16;
  // Highest value the 3-bit command field can carry; codes above CMD_READ are ignored.
  localparam logic [CMD_W-1:0] CMD_TOP = 3'd7;

  // How the SDA sample is driven over a whole command.
  typedef enum logic [1:0] {
    LINE_LOW,
    LINE_HIGH,
    LINE_NOISE
  } line_mode_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [DELAY_CFG_W-1:0] cfg_wdata;

  i2cm_req_if req_bus ();
  i2cm_rsp_if rsp_bus ();

  i2c_bit_level_master_top #(
    .DELAY_COUNTER_BITS(COUNTER_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_bus),
    .rsp      (rsp_bus),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Tick predictor: its own copy of the sequencer state and of delay_ticks.
  // Starts from the reset state; reset is applied once, so no re-init needed.
  // ---------------------------------------------------------------------------
  logic [DELAY_CFG_W-1:0]  delay_cfg = DELAY_RESET;
  op_t                     cur_op    = OP_IDLE;
  logic [5:0]              step      = '0;
  logic [BIT_IDX_W-1:0]    bit_cnt   = '0;
  logic [BYTE_W-1:0]       shifter   = '0;
  logic [COUNTER_BITS-1:0] unit_cnt  = '0;
  logic                    scl_low   = 1'b0;
  logic                    sda_low   = 1'b0;
  logic                    nak_sel   = 1'b0;
  logic                    ack_seen  = 1'b0;
  logic [BYTE_W-1:0]       last_rd   = '0;

  // Pin/status values still owed by the block, oldest first.
  result_t awaited_status[$];
  result_t oldest_status;
  int unsigned mismatch_count = 0;

  // Both sides insert random gaps only while this is set.
  bit idling_on = 1'b1;

  // Reload value of the delay counter: zero acts as one, clipped to the counter.
  function automatic logic [COUNTER_BITS-1:0] unit_reload();
    longint unsigned ceiling;
    longint unsigned span;
    ceiling = (64'd1 << COUNTER_BITS) - 64'd1;
    span    = (delay_cfg == '0) ? 64'd0 : longint'(delay_cfg) - 64'd1;
    return (span > ceiling) ? ceiling[COUNTER_BITS-1:0] : span[COUNTER_BITS-1:0];
  endfunction

  // Pin action or SDA sample on the first tick of the current step.
  function automatic void pin_action(input logic sda);
    case (cur_op)
      OP_START: begin
        case (step)
          6'd1: scl_low = 1'b0;
          6'd2: sda_low = 1'b1;
          6'd3: scl_low = 1'b1;
          default: ;
        endcase
      end
      OP_STOP: begin
        case (step)
          6'd1: sda_low = 1'b1;
          6'd2: scl_low = 1'b1;
          6'd3: scl_low = 1'b0;
          6'd4: sda_low = 1'b0;
          default: ;
        endcase
      end
      OP_WRITE: begin
        case (step)
          6'd1: scl_low = 1'b1;
          6'd2: begin
            sda_low = ~shifter[BYTE_W-1];
            shifter = shifter << 1;
          end
          6'd3: scl_low = 1'b0;
          6'd5: begin
            scl_low = 1'b1;
            bit_cnt = bit_cnt + BIT_IDX_W'(1);
            if (bit_cnt >= BITS_PER_BYTE) sda_low = 1'b0;  // let the slave ack
          end
          6'd6: scl_low = 1'b0;
          6'd8: begin
            ack_seen = sda;
            scl_low  = 1'b1;
          end
          default: ;
        endcase
      end
      OP_READ: begin
        case (step)
          6'd0: sda_low = 1'b0;
          6'd1: scl_low = 1'b0;
          6'd3: begin
            shifter = {shifter[BYTE_W-2:0], sda};
            scl_low = 1'b1;
            bit_cnt = bit_cnt + BIT_IDX_W'(1);
          end
          6'd5: sda_low = ~nak_sel;  // ACK pulls low, NAK releases
          6'd7: scl_low = 1'b0;
          6'd9: scl_low = 1'b1;
          default: ;
        endcase
      end
      default: ;
    endcase
  endfunction

  // Advance the predictor by one tick and return the outputs after it.
  function automatic result_t predict_bus_tick(input logic [CMD_W-1:0] code,
                                               input logic [BYTE_W-1:0] data,
                                               input logic nak, input logic sda);
    result_t status;
    op_t     launch;
    logic    finished;
    logic    more;
    finished = 1'b0;
    if (cur_op == OP_IDLE) begin
      case (code)
        CMD_START: launch = OP_START;
        CMD_STOP:  launch = OP_STOP;
        CMD_WRITE: launch = OP_WRITE;
        CMD_READ:  launch = OP_READ;
        default:   launch = OP_IDLE;  // none and the unused codes
      endcase
      if (launch != OP_IDLE) begin
        cur_op  = launch;
        step    = '0;
        bit_cnt = '0;
        if (launch == OP_WRITE) shifter = data;
        else if (launch == OP_READ) shifter = '0;
        nak_sel = nak;
        pin_action(sda);
        unit_cnt = unit_reload();
      end
    end else if (unit_cnt != '0) begin
      unit_cnt = unit_cnt - COUNTER_BITS'(1);
    end else begin
      more = 1'b1;
      case (cur_op)
        OP_START: if (step >= 6'd3) more = 1'b0; else step = step + 6'd1;
        OP_STOP:  if (step >= 6'd4) more = 1'b0; else step = step + 6'd1;
        OP_WRITE: begin
          if (step >= 6'd8) more = 1'b0;
          else if (step == 6'd5) step = (bit_cnt < BITS_PER_BYTE) ? 6'd2 : 6'd6;
          else step = step + 6'd1;
        end
        OP_READ: begin
          if (step >= 6'd9) more = 1'b0;
          else if (step == 6'd3) step = (bit_cnt < BITS_PER_BYTE) ? 6'd4 : 6'd5;
          else if (step == 6'd4) step = 6'd1;
          else step = step + 6'd1;
        end
        default: more = 1'b0;
      endcase
      if (more) begin
        pin_action(sda);
        unit_cnt = unit_reload();
      end else begin
        // the tick after the last unit: go idle and pulse done
        if (cur_op == OP_READ) last_rd = shifter;
        cur_op   = OP_IDLE;
        step     = '0;
        finished = 1'b1;
      end
    end
    status.scl_drive_low = scl_low;
    status.sda_drive_low = sda_low;
    status.busy_res      = (cur_op != OP_IDLE);
    status.done_res      = finished;
    status.read_byte     = last_rd;
    status.no_ack        = ack_seen;
    return status;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Far above the slowest legal run, with the longest gaps on both sides.
  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Mostly no gap, some short ones, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!idling_on || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, and the in-order check of each transaction
  // ---------------------------------------------------------------------------
  initial begin : rsp_backpressure
    int unsigned gap;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      gap = pick_gap();
      if (gap == 0) begin
        rsp_bus.ready <= 1'b1;
      end else begin
        rsp_bus.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  end

  function automatic void compare_field(input string label, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, label, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (awaited_status.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: result transaction with nothing expected", $time);
      end else begin
        oldest_status = awaited_status.pop_front();
        compare_field("scl_drive_low", 8'(oldest_status.scl_drive_low),
                      8'(rsp_bus.scl_drive_low));
        compare_field("sda_drive_low", 8'(oldest_status.sda_drive_low),
                      8'(rsp_bus.sda_drive_low));
        compare_field("busy_res", 8'(oldest_status.busy_res), 8'(rsp_bus.busy_res));
        compare_field("done_res", 8'(oldest_status.done_res), 8'(rsp_bus.done_res));
        compare_field("read_byte", oldest_status.read_byte, rsp_bus.read_byte);
        compare_field("no_ack", 8'(oldest_status.no_ack), 8'(rsp_bus.no_ack));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Send one tick; valid stays high after the transaction so back-to-back ticks
  // never see valid dropped and raised in the same time step.
  task automatic drive_tick(input logic [CMD_W-1:0] code, input logic [BYTE_W-1:0] data,
                            input logic nak, input logic sda);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      req_bus.valid <= 1'b0;
    end
    @(negedge clk);
    req_bus.valid      <= 1'b1;
    req_bus.cmd        <= code;
    req_bus.write_byte <= data;
    req_bus.nak_reply  <= nak;
    req_bus.sda_in     <= sda;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    awaited_status.push_back(predict_bus_tick(code, data, nak, sda));
  endtask

  // Stop sending and wait until every owed result is back, then let the output
  // register and queue empty.
  task automatic settle();
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (awaited_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // delay_ticks is only changed with the sequencer idle and the pipe empty.
  task automatic write_delay(input logic [DELAY_CFG_W-1:0] ticks);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(negedge clk);
    cfg_we    <= 1'b0;
    delay_cfg = ticks;
  endtask

  function automatic logic line_level(input line_mode_t line);
    case (line)
      LINE_LOW:  return 1'b0;
      LINE_HIGH: return 1'b1;
      default:   return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // Issue one command, then tick until the sequencer is idle again. busy_code
  // rides on every busy tick, the done tick included, and must be dropped.
  task automatic run_command(input logic [CMD_W-1:0] code, input logic [BYTE_W-1:0] data,
                             input logic nak, input line_mode_t line,
                             input logic [CMD_W-1:0] busy_code);
    drive_tick(code, data, nak, line_level(line));
    while (cur_op != OP_IDLE)
      drive_tick(busy_code, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 line_level(line));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Idle ticks straight out of reset, then start/stop at the reset delay of 10.
  task automatic test_reset_defaults();
    repeat (3) drive_tick(CMD_NONE, 8'h00, 1'b0, 1'b1);
    run_command(CMD_START, 8'h00, 1'b0, LINE_NOISE, CMD_NONE);
    run_command(CMD_STOP, 8'hFF, 1'b1, LINE_NOISE, CMD_NONE);
  endtask

  // Every command at the shortest unit, with byte and ACK/NAK extremes.
  task automatic test_command_set();
    write_delay(16'd1);
    run_command(CMD_START, 8'h00, 1'b0, LINE_NOISE, CMD_NONE);
    run_command(CMD_WRITE, 8'hFF, 1'b0, LINE_HIGH, CMD_NONE);  // slave NAKs
    run_command(CMD_WRITE, 8'h00, 1'b1, LINE_LOW, CMD_NONE);   // slave ACKs
    run_command(CMD_READ, 8'h00, 1'b1, LINE_HIGH, CMD_NONE);   // 0xFF, master NAK
    run_command(CMD_READ, 8'hFF, 1'b0, LINE_LOW, CMD_NONE);    // 0x00, master ACK
    run_command(CMD_WRITE, 8'hA5, 1'b0, LINE_NOISE, CMD_NONE);
    run_command(CMD_READ, 8'h5A, 1'b0, LINE_NOISE, CMD_NONE);
    run_command(CMD_STOP, 8'h00, 1'b0, LINE_NOISE, CMD_NONE);
  endtask

  // Unused codes while idle, and commands that land on busy or done ticks.
  task automatic test_ignored_codes();
    for (int code = CMD_NONE; code <= CMD_TOP; code++)
      if (code == CMD_NONE || code > CMD_READ)
        run_command(CMD_W'(code), 8'h3C, 1'b1, LINE_NOISE, CMD_NONE);
    run_command(CMD_START, 8'h00, 1'b0, LINE_NOISE, CMD_WRITE);
    run_command(CMD_WRITE, 8'hC3, 1'b0, LINE_NOISE, CMD_READ);
    run_command(CMD_READ, 8'h00, 1'b1, LINE_NOISE, CMD_STOP);
    run_command(CMD_STOP, 8'h00, 1'b0, LINE_NOISE, CMD_START);
  endtask

  // A delay of zero must behave as one.
  task automatic test_zero_delay();
    write_delay(16'd0);
    run_command(CMD_WRITE, 8'h81, 1'b0, LINE_NOISE, CMD_NONE);
    run_command(CMD_READ, 8'h00, 1'b0, LINE_NOISE, CMD_NONE);
  endtask

  // Longer delay unit: one start command at 30 ticks per unit, no gaps.
  task automatic test_long_delay();
    idling_on = 1'b0;
    write_delay(16'd30);
    run_command(CMD_START, 8'h00, 1'b0, LINE_NOISE, CMD_NONE);
    idling_on = 1'b1;
  endtask

  // Mostly well-formed command traffic with random content; while busy, random
  // noise on the command field. Runs past the count until the sequencer idles.
  task automatic test_random_traffic(input logic [DELAY_CFG_W-1:0] ticks,
                                     input int unsigned count);
    logic [CMD_W-1:0] code;
    int unsigned roll;
    write_delay(ticks);
    for (int unsigned n = 0; n < count || cur_op != OP_IDLE; n++) begin
      if (n % 100 == 0) idling_on = ($urandom_range(0, 3) != 0);
      // hold off until the block has drained, then carry on
      if (n == count / 2 || $urandom_range(0, 199) == 0) settle();
      roll = $urandom_range(0, 99);
      if (cur_op == OP_IDLE && n < count) begin
        if (roll < 85) code = CMD_W'($urandom_range(CMD_START, CMD_READ));
        else if (roll < 93) code = CMD_NONE;
        else code = CMD_W'($urandom_range(CMD_READ + 1, CMD_TOP));
      end else begin
        code = (roll < 25) ? CMD_W'($urandom_range(CMD_NONE, CMD_TOP)) : CMD_NONE;
      end
      drive_tick(code, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    end
    idling_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    req_bus.valid      = 1'b0;
    req_bus.cmd        = CMD_NONE;
    req_bus.write_byte = '0;
    req_bus.nak_reply  = 1'b0;
    req_bus.sda_in     = 1'b1;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_command_set();
    test_ignored_codes();
    test_zero_delay();
    test_long_delay();
    test_random_traffic(16'd1, 450);
    test_random_traffic(16'd2, 300);
    test_random_traffic(16'd0, 120);
    test_random_traffic(16'd3, 230);

    settle();
    repeat (10) @(posedge clk);
    if (awaited_status.size() != 0) begin
      mismatch_count++;
      $display("%0t ns: %0d expected results never arrived", $time, awaited_status.size());
    end
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
